@@ sv/ssrm_pkg.sv @@
// Shared types and constants for the sprite slot residency manager.
`default_nettype none

package ssrm_pkg;

    // Default configuration
    localparam int NUM_SLOTS_DEF   = 16;
    localparam int NUM_SPRITES_DEF = 64;

    // Fixed field widths of the channel words
    localparam int SPR_FW   = 6;
    localparam int SLOT_FW  = 4;
    localparam int FRAME_W  = 32;

    typedef enum logic {
        CMD_MARK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [SPR_FW-1:0]  sprite_id;
        logic [FRAME_W-1:0] frame;
    } in_word_t;

    typedef struct packed {
        logic [SPR_FW-1:0]  loaded_sprite;
        logic [SLOT_FW-1:0] slot;
        logic               evicted_valid;
        logic [SPR_FW-1:0]  evicted_sprite;
        logic               no_slot;
        logic               last;
    } out_word_t;

endpackage

`default_nettype wire

@@ sv/sprite_slot_residency_manager.sv @@
// Sprite slot residency manager: mark/load sequencer around state memories.
//
// Input channel (s_valid/s_ready/s_data) takes one command word at a time.
// A mark word stamps a sprite with the frame number and queues it once if
// it is not resident; it gives no result. A load word drains the queue and
// gives one result word per queued sprite handled on the m_ valid/ready
// channel, the final one with last set. For each queue entry a load fetches
// the entry and then assigns a fresh slot, or runs the eviction search: a
// search step and an owner read per slot scanned, and a stamp read for an
// occupied one; an occupied slot that is picked is evicted before the
// assign, and a failed search reports instead. Entries beyond the slot
// count give no result. The sequencer is bound by the single read port of
// each state memory; it takes a new command word only when the previous
// one is finished.
// The result register parts the two sides: a waiting result does not block
// a new command, but a load stalls at its next result until the receiver
// takes the previous one.
// Reset clears the per-entry valid bits at once; no clearing pass is run,
// and the block accepts a word in the first cycle after reset.
`default_nettype none

module sprite_slot_residency_manager #(
    parameter int NUM_SLOTS   = ssrm_pkg::NUM_SLOTS_DEF,
    parameter int NUM_SPRITES = ssrm_pkg::NUM_SPRITES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ssrm_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ssrm_pkg::out_word_t      m_data
);

    import ssrm_pkg::*;

    localparam int SPR_W  = $clog2(NUM_SPRITES);
    localparam int CNT_W  = $clog2(NUM_SPRITES + 1);
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SCNT_W = $clog2(NUM_SLOTS + 1);
    localparam int RES_W  = $clog2(NUM_SLOTS + 2);

    localparam logic [RES_W-1:0] CODE_QUEUED = RES_W'(NUM_SLOTS);
    localparam logic [RES_W-1:0] CODE_ABSENT = RES_W'(NUM_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MARK,
        S_QRD,
        S_QDATA,
        S_SRCH,
        S_SOWN,
        S_SLSF,
        S_EVICT,
        S_ASSIGN
    } state_t;

    // State memories
    logic [RES_W-1:0]   res_mem [NUM_SPRITES];
    logic [FRAME_W-1:0] lsf_mem [NUM_SPRITES];
    logic [SPR_W-1:0]   own_mem [NUM_SLOTS];
    logic [SPR_W-1:0]   pq_mem  [NUM_SPRITES];

    // Per-entry valid bits
    logic [NUM_SPRITES-1:0] res_vld_reg;
    logic [NUM_SPRITES-1:0] lsf_vld_reg;
    logic [NUM_SLOTS-1:0]   own_vld_reg;

    // Memory ports
    logic               res_we, lsf_we, own_we, pq_we;
    logic [SPR_W-1:0]   res_waddr, lsf_waddr, pq_waddr;
    logic [SLOT_W-1:0]  own_waddr;
    logic [RES_W-1:0]   res_wdata;
    logic [FRAME_W-1:0] lsf_wdata;
    logic [SPR_W-1:0]   own_wdata, pq_wdata;
    logic [SPR_W-1:0]   res_raddr, lsf_raddr, pq_raddr;
    logic [SLOT_W-1:0]  own_raddr;
    logic [RES_W-1:0]   res_rdata_reg;
    logic [FRAME_W-1:0] lsf_rdata_reg;
    logic [SPR_W-1:0]   own_rdata_reg, pq_rdata_reg;
    logic               res_rvld_reg, lsf_rvld_reg, own_rvld_reg;

    // Control and working registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   q_reg, q_next;
    logic [SCNT_W-1:0]  fresh_reg, fresh_next;
    logic [SCNT_W-1:0]  search_reg, search_next;
    logic               mark_ok_reg, mark_ok_next;
    logic [SPR_W-1:0]   sid_reg, sid_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [SPR_W-1:0]   spr_reg, spr_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SPR_W-1:0]   owner_reg, owner_next;
    logic               owner_vld_reg, owner_vld_next;
    logic               m_valid_reg, m_valid_next;
    out_word_t          m_word_reg, m_word_next;

    logic               out_free;
    logic               advance;
    logic               q_last_entry;
    logic               q_last_result;
    logic [FRAME_W-1:0] owner_stamp;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    assign out_free      = !m_valid_reg || m_ready;
    assign q_last_entry  = ((q_reg + CNT_W'(1)) == count_reg);
    assign q_last_result = q_last_entry || ((32'(q_reg) + 32'd1) == NUM_SLOTS);
    assign owner_stamp   = lsf_rvld_reg ? lsf_rdata_reg : '0;

    // Read addresses follow the input word and the working registers
    assign res_raddr = SPR_W'(s_data.sprite_id);
    assign pq_raddr  = q_reg[SPR_W-1:0];
    assign own_raddr = search_reg[SLOT_W-1:0];
    assign lsf_raddr = own_rdata_reg;

    // Sequence commands and queue entries
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        q_next         = q_reg;
        fresh_next     = fresh_reg;
        search_next    = search_reg;
        mark_ok_next   = mark_ok_reg;
        sid_next       = sid_reg;
        frame_next     = frame_reg;
        spr_next       = spr_reg;
        slot_next      = slot_reg;
        owner_next     = owner_reg;
        owner_vld_next = owner_vld_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_word_next    = m_word_reg;
        advance        = 1'b0;

        res_we    = 1'b0;
        res_waddr = spr_reg;
        res_wdata = CODE_ABSENT;
        lsf_we    = 1'b0;
        lsf_waddr = spr_reg;
        lsf_wdata = frame_reg;
        own_we    = 1'b0;
        own_waddr = slot_reg;
        own_wdata = spr_reg;
        pq_we     = 1'b0;
        pq_waddr  = count_reg[SPR_W-1:0];
        pq_wdata  = sid_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sid_next   = SPR_W'(s_data.sprite_id);
                    frame_next = s_data.frame;
                    if (s_data.cmd == CMD_MARK) begin
                        mark_ok_next = (32'(s_data.sprite_id) < NUM_SPRITES);
                        state_next   = S_MARK;
                    end else begin
                        q_next      = '0;
                        search_next = '0;
                        if (count_reg != '0) begin
                            state_next = S_QRD;
                        end
                    end
                end
            end
            S_MARK: begin
                // Stamp the sprite and queue it once if not resident
                if (mark_ok_reg) begin
                    lsf_we    = 1'b1;
                    lsf_waddr = sid_reg;
                    if ((!res_rvld_reg || res_rdata_reg == CODE_ABSENT) &&
                        (32'(count_reg) < NUM_SPRITES)) begin
                        res_we     = 1'b1;
                        res_waddr  = sid_reg;
                        res_wdata  = CODE_QUEUED;
                        pq_we      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                state_next = S_IDLE;
            end
            S_QRD: begin
                state_next = S_QDATA;
            end
            S_QDATA: begin
                spr_next = pq_rdata_reg;
                if (32'(q_reg) >= NUM_SLOTS) begin
                    // Drop entries beyond the slot count
                    res_we    = 1'b1;
                    res_waddr = pq_rdata_reg;
                    res_wdata = CODE_ABSENT;
                    advance   = 1'b1;
                end else if (32'(fresh_reg) < NUM_SLOTS) begin
                    // A never-used slot has no owner
                    slot_next      = fresh_reg[SLOT_W-1:0];
                    fresh_next     = fresh_reg + SCNT_W'(1);
                    owner_vld_next = 1'b0;
                    state_next     = S_ASSIGN;
                end else begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (32'(search_reg) >= NUM_SLOTS) begin
                    // Search exhausted: report and leave the sprite unloaded
                    if (out_free) begin
                        res_we       = 1'b1;
                        res_wdata    = CODE_ABSENT;
                        m_valid_next = 1'b1;
                        m_word_next.loaded_sprite  = SPR_FW'(spr_reg);
                        m_word_next.slot           = '0;
                        m_word_next.evicted_valid  = 1'b0;
                        m_word_next.evicted_sprite = '0;
                        m_word_next.no_slot        = 1'b1;
                        m_word_next.last           = q_last_result;
                        advance      = 1'b1;
                    end
                end else begin
                    state_next = S_SOWN;
                end
            end
            S_SOWN: begin
                owner_next     = own_rdata_reg;
                owner_vld_next = own_rvld_reg;
                if (!own_rvld_reg) begin
                    slot_next   = search_reg[SLOT_W-1:0];
                    search_next = search_reg + SCNT_W'(1);
                    state_next  = S_ASSIGN;
                end else begin
                    state_next = S_SLSF;
                end
            end
            S_SLSF: begin
                // Skip slots whose owner was stamped this frame
                search_next = search_reg + SCNT_W'(1);
                if (owner_stamp == frame_reg) begin
                    state_next = S_SRCH;
                end else begin
                    slot_next  = search_reg[SLOT_W-1:0];
                    state_next = S_EVICT;
                end
            end
            S_EVICT: begin
                res_we     = 1'b1;
                res_waddr  = owner_reg;
                res_wdata  = CODE_ABSENT;
                state_next = S_ASSIGN;
            end
            S_ASSIGN: begin
                if (out_free) begin
                    res_we       = 1'b1;
                    res_wdata    = RES_W'(slot_reg);
                    lsf_we       = 1'b1;
                    own_we       = 1'b1;
                    m_valid_next = 1'b1;
                    m_word_next.loaded_sprite  = SPR_FW'(spr_reg);
                    m_word_next.slot           = SLOT_FW'(slot_reg);
                    m_word_next.evicted_valid  = owner_vld_reg;
                    m_word_next.evicted_sprite = owner_vld_reg ? SPR_FW'(owner_reg) : '0;
                    m_word_next.no_slot        = 1'b0;
                    m_word_next.last           = q_last_result;
                    advance      = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Move to the next queue entry or finish the load
        if (advance) begin
            if (q_last_entry) begin
                count_next = '0;
                state_next = S_IDLE;
            end else begin
                q_next     = q_reg + CNT_W'(1);
                state_next = S_QRD;
            end
        end
    end

    // Hold state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            fresh_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
        q_reg         <= q_next;
        search_reg    <= search_next;
        mark_ok_reg   <= mark_ok_next;
        sid_reg       <= sid_next;
        frame_reg     <= frame_next;
        spr_reg       <= spr_next;
        slot_reg      <= slot_next;
        owner_reg     <= owner_next;
        owner_vld_reg <= owner_vld_next;
        m_word_reg    <= m_word_next;
    end

    // Track written entries; an unwritten entry reads as its reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= '0;
            lsf_vld_reg <= '0;
            own_vld_reg <= '0;
        end else begin
            if (res_we) begin
                res_vld_reg[res_waddr] <= 1'b1;
            end
            if (lsf_we) begin
                lsf_vld_reg[lsf_waddr] <= 1'b1;
            end
            if (own_we) begin
                own_vld_reg[own_waddr] <= 1'b1;
            end
        end
    end

    // Residency memory
    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_rdata_reg <= res_mem[res_raddr];
        res_rvld_reg  <= res_vld_reg[res_raddr];
    end

    // Frame stamp memory
    always_ff @(posedge aclk) begin
        if (lsf_we) begin
            lsf_mem[lsf_waddr] <= lsf_wdata;
        end
        lsf_rdata_reg <= lsf_mem[lsf_raddr];
        lsf_rvld_reg  <= lsf_vld_reg[lsf_raddr];
    end

    // Slot owner memory
    always_ff @(posedge aclk) begin
        if (own_we) begin
            own_mem[own_waddr] <= own_wdata;
        end
        own_rdata_reg <= own_mem[own_raddr];
        own_rvld_reg  <= own_vld_reg[own_raddr];
    end

    // Pending queue memory
    always_ff @(posedge aclk) begin
        if (pq_we) begin
            pq_mem[pq_waddr] <= pq_wdata;
        end
        pq_rdata_reg <= pq_mem[pq_raddr];
    end

endmodule

`default_nettype wire

@@ sv/ssrm_checker.sv @@
// Port-level assertions for the sprite slot residency manager, with bind.
`default_nettype none

module ssrm_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire ssrm_pkg::in_word_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire ssrm_pkg::out_word_t m_data
);

    import ssrm_pkg::*;

    logic mark_accept;

    assign mark_accept = s_valid && s_ready && (s_data.cmd == CMD_MARK);

    // Hold a stalled result word
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    // Drop any result during reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Mark words give no result
    a_mark_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        mark_accept && !m_valid |=> !m_valid)
        else $error("result appeared after a mark word");

    // A mark occupies the sequencer for its write-back cycle
    a_mark_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mark_accept |=> !s_ready)
        else $error("word accepted during mark write-back");

    // Failed search and missing eviction carry zero fields
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.no_slot || !m_data.evicted_valid) |->
            (m_data.evicted_sprite == '0) &&
            (!m_data.no_slot || (m_data.slot == '0 && !m_data.evicted_valid)))
        else $error("nonzero field on failed or eviction-free result");

endmodule

bind sprite_slot_residency_manager ssrm_checker u_ssrm_checker (.*);

`default_nettype wire

@@ bench/sprite_slot_residency_manager_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sprite slot residency manager: table-driven and random words.
module sprite_slot_residency_manager_tb;
    import ssrm_pkg::*;

    localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
    localparam int NUM_SPRITES = NUM_SPRITES_DEF;

    // Residency codes beside a slot index, and the empty owner marker
    localparam logic [4:0] CODE_QUEUED = 5'(NUM_SLOTS);
    localparam logic [4:0] CODE_ABSENT = 5'(NUM_SLOTS + 1);
    localparam logic [6:0] OWNER_EMPTY = 7'd127;

    // A load may drop up to 48 entries with no word moving
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 110;
    localparam int NUM_ROWS     = 9;

    typedef struct packed {
        cmd_t               cmd;
        logic [SPR_FW-1:0]  sprite_id;
        logic [FRAME_W-1:0] frame;
        logic [4:0]         rep;       // repeat count, sprite id steps by one
        logic               typed;     // res holds the single expected word
        out_word_t          res;
    } dir_row_t;

    // Directed words: empty load, extremes, queue overflow with eviction, failed search
    localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{CMD_LOAD, 6'd0,  32'd0,         5'd1,  1'b0, '0},
        '{CMD_MARK, 6'd0,  32'd0,         5'd1,  1'b0, '0},
        '{CMD_LOAD, 6'd0,  32'd0,         5'd1,  1'b1,
          '{6'd0, 4'd0, 1'b0, 6'd0, 1'b0, 1'b1}},
        '{CMD_MARK, 6'd63, 32'hFFFF_FFFF, 5'd1,  1'b0, '0},
        '{CMD_LOAD, 6'd0,  32'hFFFF_FFFF, 5'd1,  1'b1,
          '{6'd63, 4'd1, 1'b0, 6'd0, 1'b0, 1'b1}},
        '{CMD_MARK, 6'd1,  32'd5,         5'd17, 1'b0, '0},
        '{CMD_LOAD, 6'd0,  32'd5,         5'd1,  1'b0, '0},
        '{CMD_MARK, 6'd0,  32'd5,         5'd1,  1'b0, '0},
        '{CMD_LOAD, 6'd0,  32'd5,         5'd1,  1'b1,
          '{6'd0, 4'd0, 1'b0, 6'd0, 1'b1, 1'b1}}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // Predicted block state
    logic [4:0]         sprite_state [NUM_SPRITES];
    logic [FRAME_W-1:0] seen_frame   [NUM_SPRITES];
    logic [6:0]         owner_of     [NUM_SLOTS];
    logic [SPR_FW-1:0]  load_list    [NUM_SPRITES];
    int                 fresh_slot;
    int                 queued_cnt;

    out_word_t          expected_words [$];
    out_word_t          load_words     [$];
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 fail_cnt = 0;
    int                 stall_cycles = 0;
    logic [FRAME_W-1:0] cur_frame;

    sprite_slot_residency_manager dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one accepted word to the predicted state; load results land in load_words
    function automatic void apply_command(in_word_t w);
        int                search;
        int                slot;
        logic [SPR_FW-1:0] spr;
        logic [6:0]        owner;
        out_word_t         r;

        load_words.delete();
        if (w.cmd == CMD_MARK) begin
            seen_frame[w.sprite_id] = w.frame;
            if (sprite_state[w.sprite_id] == CODE_ABSENT && queued_cnt < NUM_SPRITES) begin
                sprite_state[w.sprite_id] = CODE_QUEUED;
                load_list[queued_cnt] = w.sprite_id;
                queued_cnt++;
            end
            return;
        end

        search = 0;
        for (int q = 0; q < queued_cnt; q++) begin
            spr = load_list[q];
            r = '0;
            r.loaded_sprite = spr;
            // Drop entries past the slot count
            if (q >= NUM_SLOTS) begin
                sprite_state[spr] = CODE_ABSENT;
                continue;
            end
            if (fresh_slot < NUM_SLOTS) begin
                slot = fresh_slot;
                fresh_slot++;
            end else begin
                // Skip slots whose owner was stamped this frame
                while (search < NUM_SLOTS && owner_of[search] != OWNER_EMPTY &&
                       seen_frame[owner_of[search][SPR_FW-1:0]] == w.frame)
                    search++;
                if (search >= NUM_SLOTS) begin
                    sprite_state[spr] = CODE_ABSENT;
                    r.no_slot = 1'b1;
                    load_words.push_back(r);
                    continue;
                end
                slot = search;
                search++;
            end
            owner = owner_of[slot];
            if (owner != OWNER_EMPTY) begin
                sprite_state[owner[SPR_FW-1:0]] = CODE_ABSENT;
                r.evicted_valid  = 1'b1;
                r.evicted_sprite = owner[SPR_FW-1:0];
            end
            sprite_state[spr] = 5'(slot);
            seen_frame[spr]   = w.frame;
            owner_of[slot]    = {1'b0, spr};
            r.slot = SLOT_FW'(slot);
            load_words.push_back(r);
        end
        queued_cnt = 0;
        // Flag the final word of the load
        if (load_words.size() > 0) begin
            r = load_words.pop_back();
            r.last = 1'b1;
            load_words.push_back(r);
        end
    endfunction

    // Offer one word after a random idle gap, hold it until taken, then predict
    task automatic send_word(in_word_t w, logic typed, out_word_t typed_res);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        apply_command(w);
        if (typed)
            expected_words.push_back(typed_res);
        else
            foreach (load_words[i]) expected_words.push_back(load_words[i]);
    endtask

    // Hold the input side until every predicted word has come back
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // Mostly frames of marks closed by a load, plus stray marks and loads
    task automatic run_random(int n_items);
        int       sent;
        int       marks;
        int       pick;
        in_word_t w;

        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                // Advance the frame, keep it, or jump it (near wrap now and then)
                case ($urandom_range(0, 19))
                    0:       cur_frame = $urandom;
                    1:       cur_frame = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
                    2, 3, 4: cur_frame = cur_frame;
                    default: cur_frame = cur_frame + 1;
                endcase
                marks = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6)
                                                   : $urandom_range(12, 24);
                for (int k = 0; k < marks; k++) begin
                    w.cmd       = CMD_MARK;
                    w.sprite_id = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                              : 6'($urandom_range(0, 19));
                    w.frame     = cur_frame;
                    send_word(w, 1'b0, '0);
                end
                w.cmd       = CMD_LOAD;
                w.sprite_id = 6'($urandom);
                w.frame     = cur_frame;
                send_word(w, 1'b0, '0);
                sent += marks + 1;
            end else begin
                w.cmd       = (pick < 90) ? CMD_MARK : CMD_LOAD;
                w.sprite_id = 6'($urandom);
                w.frame     = ($urandom_range(0, 1) == 0) ? cur_frame : 32'($urandom);
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Stall the result side at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each taken result word with the oldest prediction
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: loaded_sprite %0d slot %0d",
                       m_data.loaded_sprite, m_data.slot);
                fail_cnt++;
            end else begin
                exp_w = expected_words.pop_front();
                if (m_data.loaded_sprite !== exp_w.loaded_sprite) begin
                    $error("loaded_sprite: expected %0d, got %0d",
                           exp_w.loaded_sprite, m_data.loaded_sprite);
                    fail_cnt++;
                end
                if (m_data.slot !== exp_w.slot) begin
                    $error("slot: expected %0d, got %0d", exp_w.slot, m_data.slot);
                    fail_cnt++;
                end
                if (m_data.evicted_valid !== exp_w.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d",
                           exp_w.evicted_valid, m_data.evicted_valid);
                    fail_cnt++;
                end
                if (m_data.evicted_sprite !== exp_w.evicted_sprite) begin
                    $error("evicted_sprite: expected %0d, got %0d",
                           exp_w.evicted_sprite, m_data.evicted_sprite);
                    fail_cnt++;
                end
                if (m_data.no_slot !== exp_w.no_slot) begin
                    $error("no_slot: expected %0d, got %0d", exp_w.no_slot, m_data.no_slot);
                    fail_cnt++;
                end
                if (m_data.last !== exp_w.last) begin
                    $error("last: expected %0d, got %0d", exp_w.last, m_data.last);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sprite_slot_residency_manager test failed");
            $finish;
        end
    end

    initial begin
        in_word_t w;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_frame      = 32'd100;
        for (int i = 0; i < NUM_SPRITES; i++) begin
            sprite_state[i] = CODE_ABSENT;
            seen_frame[i]   = '0;
            load_list[i]    = '0;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            owner_of[i] = OWNER_EMPTY;
        fresh_slot = 0;
        queued_cnt = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table with no idling
        for (int i = 0; i < NUM_ROWS; i++) begin
            for (int k = 0; k < DIRECTED_ROWS[i].rep; k++) begin
                w.cmd       = DIRECTED_ROWS[i].cmd;
                w.sprite_id = DIRECTED_ROWS[i].sprite_id + 6'(k);
                w.frame     = DIRECTED_ROWS[i].frame;
                send_word(w, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
            end
        end
        hold_until_drained();

        // Random phases: no idling, sender idle, receiver stalling, both
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            run_random(PHASE_ITEMS);
            hold_until_drained();
        end

        // Watch for stray words after the last load has settled
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0)
            $display("sprite_slot_residency_manager test passed");
        else
            $display("sprite_slot_residency_manager test failed");
        $finish;
    end

endmodule
